>>> rtl/flkal_pkg.sv
// Shared types, codes and helpers of the flocking alignment force block.
package flkal_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SQRT_STEPS = 34;
  localparam int unsigned DEF_MAX_NEIGHBOURS = 64;
  localparam int unsigned DEF_FRAC_BITS = 16;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EVAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALL_GAIN = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic signed [WORD_W-1:0] lin_vel_x;
    logic signed [WORD_W-1:0] lin_vel_y;
    logic signed [WORD_W-1:0] lin_vel_z;
    logic signed [WORD_W-1:0] ang_vel_x;
    logic signed [WORD_W-1:0] ang_vel_y;
    logic signed [WORD_W-1:0] ang_vel_z;
  } in_payload_t;

  typedef struct packed {
    logic force_valid;
    logic signed [WORD_W-1:0] force_x;
    logic signed [WORD_W-1:0] force_y;
    logic signed [WORD_W-1:0] force_z;
    logic signed [WORD_W-1:0] torque_x;
    logic signed [WORD_W-1:0] torque_y;
    logic signed [WORD_W-1:0] torque_z;
  } out_payload_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_cnt;
    logic append;
    logic capture;
    logic walk_init;
    logic rd;
    logic sq_clr;
    logic sq_mul;
    logic sq_acc;
    logic sq_src_avg;
    logic [1:0] k;
    logic sqrt_init;
    logic sqrt_step;
    logic qual;
    logic div_init;
    logic div_scale;
    logic div_step;
    logic avg_wr;
    logic [3:0] j;
    logic scale_calc;
    logic scale_one;
    logic st_mul;
    logic st_sat;
    logic [1:0] m;
    logic [2:0] c;
    logic emit;
    logic emit_valid;
  } flkal_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic walk_last;
    logic n_zero;
    logic enabled;
    logic scale_ok;
  } flkal_sts_t;

  // dividend magnitude width: neighbour sums or the scale numerator
  function automatic int unsigned div_width(input int unsigned max_nb,
                                            input int unsigned frac);
    int unsigned sw;
    int unsigned nw;
    sw = 33 + $clog2(max_nb + 1);
    nw = 36 + frac;
    return (sw > nw) ? sw : nw;
  endfunction

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sd2147483647;
    lo = -72'sd2147483648;
    if (v > hi) return 32'sh7FFFFFFF;
    if (v < lo) return 32'sh80000000;
    return v[WORD_W-1:0];
  endfunction

endpackage

>>> rtl/flkal_in_if.sv
// Input channel: valid/ready handshake with the part or neighbour payload.
interface flkal_in_if import flkal_pkg::*;;
  logic valid;
  logic ready;
  logic [FUNC_W-1:0] func;
  logic signed [WORD_W-1:0] pos_x;
  logic signed [WORD_W-1:0] pos_y;
  logic signed [WORD_W-1:0] pos_z;
  logic signed [WORD_W-1:0] lin_vel_x;
  logic signed [WORD_W-1:0] lin_vel_y;
  logic signed [WORD_W-1:0] lin_vel_z;
  logic signed [WORD_W-1:0] ang_vel_x;
  logic signed [WORD_W-1:0] ang_vel_y;
  logic signed [WORD_W-1:0] ang_vel_z;

  modport source(output valid, func, pos_x, pos_y, pos_z, lin_vel_x, lin_vel_y,
                 lin_vel_z, ang_vel_x, ang_vel_y, ang_vel_z, input ready);
  modport sink(input valid, func, pos_x, pos_y, pos_z, lin_vel_x, lin_vel_y,
               lin_vel_z, ang_vel_x, ang_vel_y, ang_vel_z, output ready);
endinterface

>>> rtl/flkal_out_if.sv
// Output channel: valid/ready handshake with the force and torque payload.
interface flkal_out_if import flkal_pkg::*;;
  logic valid;
  logic ready;
  logic force_valid;
  logic signed [WORD_W-1:0] force_x;
  logic signed [WORD_W-1:0] force_y;
  logic signed [WORD_W-1:0] force_z;
  logic signed [WORD_W-1:0] torque_x;
  logic signed [WORD_W-1:0] torque_y;
  logic signed [WORD_W-1:0] torque_z;

  modport source(output valid, force_valid, force_x, force_y, force_z, torque_x,
                 torque_y, torque_z, input ready);
  modport sink(input valid, force_valid, force_x, force_y, force_z, torque_x,
               torque_y, torque_z, output ready);
endinterface

>>> rtl/flock_alignment_force.sv
// Top level of the flocking alignment force block.
//
//  channel  | dir | transaction
//  ---------+-----+------------------------------------------------------
//  in_if    | in  | func + part pose/velocities (clear, append, evaluate)
//  out_if   | out | force_valid + saturated force and torque (evaluate)
//  cfg_*    | in  | register write, index 0..5, no read-back
//
// Clear and append complete in the cycle they are accepted. An evaluation
// walks the stored neighbours, each summing its squared offsets on the shared
// multiplier and taking 34 square-root steps; then nine averaging and one scale
// division with DW-bit quotients (DW = 52 by default) run one quotient bit per
// cycle; the scale root and division are skipped when the scale is fixed at
// one. When disabled, empty or with no neighbour in range it emits force_valid 0.
// Reset is asynchronous, active low; it empties the store and loads the
// register defaults. The result sits in an output register, so new
// transactions are taken while it waits; an evaluation that finishes
// while the previous result is still unread holds until it is taken.
module flock_alignment_force import flkal_pkg::*; #(
  parameter int unsigned MAX_NEIGHBOURS = DEF_MAX_NEIGHBOURS,
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  flkal_in_if.sink             in_if,
  flkal_out_if.source          out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  flkal_cmd_t   cmd;
  flkal_sts_t   sts;
  in_payload_t  in_pl;
  out_payload_t out_pl;

  assign in_pl.func      = in_if.func;
  assign in_pl.pos_x     = in_if.pos_x;
  assign in_pl.pos_y     = in_if.pos_y;
  assign in_pl.pos_z     = in_if.pos_z;
  assign in_pl.lin_vel_x = in_if.lin_vel_x;
  assign in_pl.lin_vel_y = in_if.lin_vel_y;
  assign in_pl.lin_vel_z = in_if.lin_vel_z;
  assign in_pl.ang_vel_x = in_if.ang_vel_x;
  assign in_pl.ang_vel_y = in_if.ang_vel_y;
  assign in_pl.ang_vel_z = in_if.ang_vel_z;

  // sequencer
  flkal_ctrl #(
    .MAX_NEIGHBOURS(MAX_NEIGHBOURS),
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_if.valid),
    .in_func_i(in_if.func),
    .out_ready_i(out_if.ready),
    .sts_i(sts),
    .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid),
    .cmd_o(cmd)
  );

  // store, arithmetic and result register
  flkal_dp #(
    .MAX_NEIGHBOURS(MAX_NEIGHBOURS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i(in_pl),
    .cmd_i(cmd),
    .sts_o(sts),
    .out_o(out_pl)
  );

  assign out_if.force_valid = out_pl.force_valid;
  assign out_if.force_x     = out_pl.force_x;
  assign out_if.force_y     = out_pl.force_y;
  assign out_if.force_z     = out_pl.force_z;
  assign out_if.torque_x    = out_pl.torque_x;
  assign out_if.torque_y    = out_pl.torque_y;
  assign out_if.torque_z    = out_pl.torque_z;

endmodule

>>> rtl/flkal_dp.sv
// Datapath: neighbour store, shared multiplier, square root and divider units.
module flkal_dp import flkal_pkg::*; #(
  parameter int unsigned MAX_NEIGHBOURS = DEF_MAX_NEIGHBOURS,
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  input  in_payload_t          in_i,
  input  flkal_cmd_t           cmd_i,
  output flkal_sts_t           sts_o,
  output out_payload_t         out_o
);

  localparam int unsigned CW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int unsigned IW = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int unsigned SW = 33 + CW;
  localparam int unsigned DW = div_width(MAX_NEIGHBOURS, FRAC_BITS);
  localparam int unsigned ENT_W = 9 * WORD_W;
  localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] MAX_RST = WORD_W'(10) << FRAC_BITS;

  // config registers
  logic en_q;
  logic signed [WORD_W-1:0] mn_q, mx_q, lgain_q, again_q, ogain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b1;
      mn_q    <= '0;
      mx_q    <= MAX_RST;
      lgain_q <= ONE;
      again_q <= ONE;
      ogain_q <= ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLED:  en_q    <= cfg_data_i[0];
        REG_MIN_DIST: mn_q    <= cfg_data_i;
        REG_MAX_DIST: mx_q    <= cfg_data_i;
        REG_LIN_GAIN: lgain_q <= cfg_data_i;
        REG_ANG_GAIN: again_q <= cfg_data_i;
        REG_ALL_GAIN: ogain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // neighbour store
  logic [ENT_W-1:0] mem [MAX_NEIGHBOURS];
  logic [ENT_W-1:0] rd_q;
  logic [ENT_W-1:0] wr_ent;
  logic [CW-1:0] cnt_q, idx_q, n_q;
  logic full;

  assign wr_ent = {in_i.ang_vel_z, in_i.ang_vel_y, in_i.ang_vel_x,
                   in_i.lin_vel_z, in_i.lin_vel_y, in_i.lin_vel_x,
                   in_i.pos_z, in_i.pos_y, in_i.pos_x};
  assign full = (cnt_q == CW'(MAX_NEIGHBOURS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) mem[cnt_q[IW-1:0]] <= wr_ent;
    if (cmd_i.rd) rd_q <= mem[idx_q[IW-1:0]];
  end

  // own part
  logic signed [WORD_W-1:0] own_pos [3];
  logic signed [WORD_W-1:0] own_v [6];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      own_pos[0] <= in_i.pos_x;
      own_pos[1] <= in_i.pos_y;
      own_pos[2] <= in_i.pos_z;
      own_v[0]   <= in_i.lin_vel_x;
      own_v[1]   <= in_i.lin_vel_y;
      own_v[2]   <= in_i.lin_vel_z;
      own_v[3]   <= in_i.ang_vel_x;
      own_v[4]   <= in_i.ang_vel_y;
      own_v[5]   <= in_i.ang_vel_z;
    end
  end

  // sums: offsets 0..2, linear 3..5, angular 6..8; later the averages
  logic signed [SW-1:0] sum_q [9];
  logic signed [33:0] d [3];
  logic signed [33:0] mag [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.sq_src_avg) d[k] = sum_q[k][33:0];
      else d[k] = 34'($signed(rd_q[WORD_W*k +: WORD_W])) - 34'(own_pos[k]);
      mag[k] = d[k][33] ? -d[k] : d[k];
    end
  end

  // shared multiplier
  logic [3:0] sidx;
  logic signed [33:0] diff, mul_a, mul_b;
  logic signed [67:0] prod_q;
  logic signed [WORD_W-1:0] scale_q, v_q;

  assign sidx = 4'(cmd_i.c) + 4'd3;
  assign diff = 34'($signed(sum_q[sidx][WORD_W-1:0])) - 34'(own_v[cmd_i.c]);

  always_comb begin
    if (cmd_i.sq_mul) begin
      mul_a = mag[cmd_i.k];
      mul_b = mag[cmd_i.k];
    end else begin
      case (cmd_i.m)
        2'd0: begin
          mul_a = diff;
          mul_b = 34'(scale_q);
        end
        2'd1: begin
          mul_a = 34'(v_q);
          mul_b = (cmd_i.c < 3'd3) ? 34'(lgain_q) : 34'(again_q);
        end
        default: begin
          mul_a = 34'(v_q);
          mul_b = 34'(ogain_q);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_mul || cmd_i.st_mul) prod_q <= mul_a * mul_b;
  end

  // sum of squares and restoring square root, one result bit a step
  logic [65:0] ssq_q;
  logic [67:0] rad_q;
  logic [35:0] srem_q;
  logic [33:0] root_q;
  logic [37:0] srem2, strial;
  logic sge;

  assign srem2  = {srem_q, rad_q[67:66]};
  assign strial = {2'b00, root_q, 2'b01};
  assign sge    = (srem2 >= strial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_clr) ssq_q <= '0;
    else if (cmd_i.sq_acc) ssq_q <= ssq_q + prod_q[65:0];
    if (cmd_i.sqrt_init) begin
      rad_q  <= {2'b00, ssq_q};
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= rad_q << 2;
      srem_q <= sge ? 36'(srem2 - strial) : srem2[35:0];
      root_q <= {root_q[32:0], sge};
    end
  end

  // qualification
  logic signed [34:0] nb_dist;
  logic in_range;

  assign nb_dist = $signed({1'b0, root_q});
  assign in_range = (nb_dist >= 35'(mn_q)) && (nb_dist <= 35'(mx_q));

  // restoring divider, one quotient bit a step
  logic [DW-1:0] dq_q;
  logic [WORD_W-1:0] drem_q, dvs_q;
  logic dsign_q;
  logic [WORD_W:0] drsh;
  logic dge;
  logic signed [DW:0] qs;
  logic signed [35:0] num;
  logic [35:0] num_mag;
  logic signed [SW-1:0] dsum;
  logic [SW-1:0] dsum_mag;
  logic signed [WORD_W:0] den;
  logic signed [DW+1:0] sc;

  assign drsh     = {drem_q, dq_q[DW-1]};
  assign dge      = (drsh >= {1'b0, dvs_q});
  assign qs       = dsign_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
  assign num      = $signed({2'b00, root_q}) - 36'(mn_q);
  assign num_mag  = num[35] ? 36'(-num) : 36'(num);
  assign dsum     = sum_q[cmd_i.j];
  assign dsum_mag = dsum[SW-1] ? SW'(-dsum) : SW'(dsum);
  assign den      = 33'(mx_q) - 33'(mn_q);
  assign sc       = (DW+2)'($signed(ONE)) - (DW+2)'(qs);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      drem_q <= '0;
      if (cmd_i.div_scale) begin
        dsign_q <= num[35];
        dq_q    <= DW'(num_mag) << FRAC_BITS;
        dvs_q   <= den[WORD_W-1:0];
      end else begin
        dsign_q <= dsum[SW-1];
        dq_q    <= DW'(dsum_mag);
        dvs_q   <= WORD_W'(n_q);
      end
    end else if (cmd_i.div_step) begin
      drem_q <= dge ? WORD_W'(drsh - {1'b0, dvs_q}) : drsh[WORD_W-1:0];
      dq_q   <= {dq_q[DW-2:0], dge};
    end
  end

  // walk counters and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      n_q   <= '0;
    end else begin
      if (cmd_i.clr_cnt) cnt_q <= '0;
      else if (cmd_i.append && !full) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.walk_init) begin
        idx_q <= '0;
        n_q   <= '0;
      end else if (cmd_i.qual) begin
        idx_q <= idx_q + 1'b1;
        if (in_range) n_q <= n_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      for (int i = 0; i < 9; i++) sum_q[i] <= '0;
    end else if (cmd_i.qual && in_range) begin
      for (int k = 0; k < 3; k++) begin
        sum_q[k]   <= sum_q[k] + SW'(d[k]);
        sum_q[3+k] <= sum_q[3+k] + SW'($signed(rd_q[WORD_W*(3+k) +: WORD_W]));
        sum_q[6+k] <= sum_q[6+k] + SW'($signed(rd_q[WORD_W*(6+k) +: WORD_W]));
      end
    end else if (cmd_i.avg_wr) begin
      sum_q[cmd_i.j] <= SW'(qs);
    end
  end

  // scale and steering chain
  logic signed [67:0] pshift;
  logic signed [WORD_W-1:0] vsat;
  logic signed [WORD_W-1:0] res_q [6];

  assign pshift = prod_q >>> FRAC_BITS;
  assign vsat   = sat32(72'(pshift));

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_calc) scale_q <= sat32(72'(sc));
    else if (cmd_i.scale_one) scale_q <= ONE;
    if (cmd_i.st_sat) begin
      v_q <= vsat;
      if (cmd_i.m == 2'd2) res_q[cmd_i.c] <= vsat;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_o.force_valid <= cmd_i.emit_valid;
      out_o.force_x  <= cmd_i.emit_valid ? res_q[0] : '0;
      out_o.force_y  <= cmd_i.emit_valid ? res_q[1] : '0;
      out_o.force_z  <= cmd_i.emit_valid ? res_q[2] : '0;
      out_o.torque_x <= cmd_i.emit_valid ? res_q[3] : '0;
      out_o.torque_y <= cmd_i.emit_valid ? res_q[4] : '0;
      out_o.torque_z <= cmd_i.emit_valid ? res_q[5] : '0;
    end
  end

  assign sts_o.full      = full;
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.walk_last = (idx_q == cnt_q - 1'b1);
  assign sts_o.n_zero    = (n_q == '0);
  assign sts_o.enabled   = en_q;
  assign sts_o.scale_ok  = !mx_q[WORD_W-1] && !mn_q[WORD_W-1] && (mx_q != mn_q);

endmodule

>>> rtl/flkal_ctrl.sv
// Controller: sequences the walk, square roots, divisions and steering chain.
module flkal_ctrl import flkal_pkg::*; #(
  parameter int unsigned MAX_NEIGHBOURS = DEF_MAX_NEIGHBOURS,
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [FUNC_W-1:0] in_func_i,
  input  logic              out_ready_i,
  input  flkal_sts_t        sts_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output flkal_cmd_t        cmd_o
);

  localparam int unsigned DW = div_width(MAX_NEIGHBOURS, FRAC_BITS);
  localparam int unsigned STEP_W = $clog2(DW);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD   = 5'd1;
  localparam logic [4:0] S_SQM  = 5'd2;
  localparam logic [4:0] S_SQA  = 5'd3;
  localparam logic [4:0] S_SQI  = 5'd4;
  localparam logic [4:0] S_SQRT = 5'd5;
  localparam logic [4:0] S_QUAL = 5'd6;
  localparam logic [4:0] S_CHK  = 5'd7;
  localparam logic [4:0] S_DVI  = 5'd8;
  localparam logic [4:0] S_DIV  = 5'd9;
  localparam logic [4:0] S_DVW  = 5'd10;
  localparam logic [4:0] S_SCD  = 5'd11;
  localparam logic [4:0] S_SCW  = 5'd12;
  localparam logic [4:0] S_SC1  = 5'd13;
  localparam logic [4:0] S_STM  = 5'd14;
  localparam logic [4:0] S_STS  = 5'd15;
  localparam logic [4:0] S_EMIT = 5'd16;

  logic [4:0] state_q, state_d;
  logic [1:0] k_q, k_d, m_q, m_d;
  logic [3:0] j_q, j_d;
  logic [2:0] c_q, c_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic avg_q, avg_d, dscale_q, dscale_d, fv_q, fv_d, ovld_q, ovld_d;
  logic accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    m_d      = m_q;
    j_d      = j_q;
    c_d      = c_q;
    step_d   = step_q;
    avg_d    = avg_q;
    dscale_d = dscale_q;
    fv_d     = fv_q;
    ovld_d   = ovld_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.k  = k_q;
    cmd_o.m  = m_q;
    cmd_o.j  = j_q;
    cmd_o.c  = c_q;
    cmd_o.sq_src_avg = avg_q;
    cmd_o.div_scale  = dscale_q;
    cmd_o.emit_valid = fv_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_func_i)
            FUNC_CLEAR:  cmd_o.clr_cnt = 1'b1;
            FUNC_APPEND: cmd_o.append = 1'b1;
            FUNC_EVAL: begin
              cmd_o.capture   = 1'b1;
              cmd_o.walk_init = 1'b1;
              avg_d    = 1'b0;
              dscale_d = 1'b0;
              if (!sts_i.enabled || sts_i.cnt_zero) begin
                fv_d    = 1'b0;
                state_d = S_EMIT;
              end else begin
                state_d = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd_o.rd     = 1'b1;
        cmd_o.sq_clr = 1'b1;
        k_d     = '0;
        state_d = S_SQM;
      end
      S_SQM: begin
        cmd_o.sq_mul = 1'b1;
        state_d = S_SQA;
      end
      S_SQA: begin
        cmd_o.sq_acc = 1'b1;
        if (k_q == 2'd2) begin
          state_d = S_SQI;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_SQM;
        end
      end
      S_SQI: begin
        cmd_o.sqrt_init = 1'b1;
        step_d  = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          if (avg_q) begin
            dscale_d = 1'b1;
            state_d  = S_SCD;
          end else begin
            state_d = S_QUAL;
          end
        end
      end
      S_QUAL: begin
        cmd_o.qual = 1'b1;
        state_d = sts_i.walk_last ? S_CHK : S_RD;
      end
      S_CHK: begin
        if (sts_i.n_zero) begin
          fv_d    = 1'b0;
          state_d = S_EMIT;
        end else begin
          j_d     = '0;
          state_d = S_DVI;
        end
      end
      S_DVI: begin
        cmd_o.div_init = 1'b1;
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DW - 1)) state_d = dscale_q ? S_SCW : S_DVW;
      end
      S_DVW: begin
        cmd_o.avg_wr = 1'b1;
        if (j_q == 4'd8) begin
          if (sts_i.scale_ok) begin
            cmd_o.sq_clr = 1'b1;
            avg_d   = 1'b1;
            k_d     = '0;
            state_d = S_SQM;
          end else begin
            state_d = S_SC1;
          end
        end else begin
          j_d     = j_q + 4'd1;
          state_d = S_DVI;
        end
      end
      S_SCD: begin
        cmd_o.div_init = 1'b1;
        step_d  = '0;
        state_d = S_DIV;
      end
      S_SCW, S_SC1: begin
        cmd_o.scale_calc = (state_q == S_SCW);
        cmd_o.scale_one  = (state_q == S_SC1);
        c_d     = '0;
        m_d     = '0;
        state_d = S_STM;
      end
      S_STM: begin
        cmd_o.st_mul = 1'b1;
        state_d = S_STS;
      end
      S_STS: begin
        cmd_o.st_sat = 1'b1;
        state_d = S_STM;
        if (m_q == 2'd2) begin
          m_d = '0;
          if (c_q == 3'd5) begin
            fv_d    = 1'b1;
            state_d = S_EMIT;
          end else begin
            c_d = c_q + 3'd1;
          end
        end else begin
          m_d = m_q + 2'd1;
        end
      end
      S_EMIT: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= '0;
      m_q      <= '0;
      j_q      <= '0;
      c_q      <= '0;
      step_q   <= '0;
      avg_q    <= 1'b0;
      dscale_q <= 1'b0;
      fv_q     <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      m_q      <= m_d;
      j_q      <= j_d;
      c_q      <= c_d;
      step_q   <= step_d;
      avg_q    <= avg_d;
      dscale_q <= dscale_d;
      fv_q     <= fv_d;
      ovld_q   <= ovld_d;
    end
  end

endmodule
